>>> hdl/bus_utilization_accumulator_core_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef BUS_UTILIZATION_ACCUMULATOR_CORE_MACROS_SVH
`define BUS_UTILIZATION_ACCUMULATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property, checked at every rising edge outside reset.
`define BUA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// Antecedent in this cycle, consequent in the next one.
`define BUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BUA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/bua_pkg.sv
package bua_pkg;

	// Item opcodes
	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// Monitor set codes
	typedef enum logic [1:0] {
		SET_DDR     = 2'd0,
		SET_RIGHT   = 2'd1,
		SET_CPU     = 2'd2,
		SET_INVALID = 2'd3
	} set_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_OVF     = 2'd1,
		STAT_INVALID = 2'd2
	} status_t;

	// Member index width: holds every set bound plus one
	localparam int MEM_W = 3;

	localparam logic [MEM_W-1:0] DDR_FIRST   = 3'd0;
	localparam logic [MEM_W-1:0] DDR_LAST    = 3'd2;
	localparam logic [MEM_W-1:0] RIGHT_FIRST = 3'd3;
	localparam logic [MEM_W-1:0] RIGHT_LAST  = 3'd3;
	localparam logic [MEM_W-1:0] CPU_FIRST   = 3'd4;
	localparam logic [MEM_W-1:0] CPU_LAST    = 3'd4;

	typedef struct packed {
		opcode_t     opcode;
		logic [2:0]  monitor_index;
		logic [31:0] data_count;
		logic [31:0] cycle_count;
		logic        cycle_overflow_in;
		set_t        set_select;
	} in_item_t;

	typedef struct packed {
		logic [30:0] busy_value;
		status_t     status;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    add;
		logic    init;
		logic    load;
		logic    step;
		logic    fold;
		logic    clear;
		logic    emit;
		status_t emit_code;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_query;
		logic set_invalid;
		logic set_ovf;
		logic member_end;
		logic div_zero;
		logic div_last;
	} sts_t;

endpackage

>>> hdl/bua_ctrl.sv
module bua_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bua_pkg::sts_t sts,
	output bua_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ADD  = 7'b0000010,
		ST_QCHK = 7'b0000100,
		ST_MEMB = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_FOLD = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign busy = (state_q != ST_IDLE);

	// Sequencing of add and query beats
	always_comb begin
		cmd       = '0;
		cmd.emit_code = bua_pkg::STAT_OK;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = sts.in_query ? ST_QCHK : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add   = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_QCHK: begin
				if (sts.set_invalid) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = bua_pkg::STAT_INVALID;
					state_nxt     = ST_IDLE;
				end else if (sts.set_ovf) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = bua_pkg::STAT_OVF;
					cmd.clear     = 1'b1;
					state_nxt     = ST_IDLE;
				end else begin
					cmd.init  = 1'b1;
					state_nxt = ST_MEMB;
				end
			end
			ST_MEMB: begin
				if (sts.member_end) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.load  = 1'b1;
					state_nxt = sts.div_zero ? ST_FOLD : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold  = 1'b1;
				state_nxt = ST_MEMB;
			end
			ST_FIN: begin
				cmd.emit      = 1'b1;
				cmd.emit_code = bua_pkg::STAT_OK;
				cmd.clear     = 1'b1;
				state_nxt     = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> hdl/bua_dp.sv
`include "bus_utilization_accumulator_core_macros.svh"

module bua_dp #(
	parameter int NUM_MONITORS = 5,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bua_pkg::in_item_t item,
	input  bua_pkg::cmd_t     cmd,
	output bua_pkg::sts_t     sts,
	output logic              done,
	output bua_pkg::result_t  result
);

	localparam int CW   = COUNT_WIDTH;
	localparam int PW   = CW + 7;                  // width of count*100
	localparam int QW   = (PW > 32) ? PW : 32;
	localparam int AW   = (NUM_MONITORS > 1) ? $clog2(NUM_MONITORS) : 1;
	localparam int CNTW = $clog2(PW);
	localparam int MW   = bua_pkg::MEM_W;

	function automatic logic [30:0] sat31(input logic [QW-1:0] v);
		if (|v[QW-1:31]) begin
			return '1;
		end
		return v[30:0];
	endfunction

	bua_pkg::in_item_t item_q;
	logic [CW-1:0]     data_sum_q  [NUM_MONITORS];
	logic [CW-1:0]     cycle_sum_q [NUM_MONITORS];
	logic [NUM_MONITORS-1:0] ovf_q;

	logic [MW-1:0]   mem_q;
	logic [CW-1:0]   div_q;
	logic [CW-1:0]   rem_q;
	logic [PW-1:0]   dq_q;
	logic [CNTW-1:0] cnt_q;
	logic            zero_q;
	logic [30:0]     zsat_q;
	logic [30:0]     best_q;
	logic            done_q;
	bua_pkg::result_t result_q;

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// Set decode
	logic [MW-1:0] set_first;
	logic [MW-1:0] set_last;
	logic          set_invalid;
	always_comb begin
		set_first   = bua_pkg::DDR_FIRST;
		set_last    = bua_pkg::DDR_LAST;
		set_invalid = 1'b0;
		case (item_q.set_select)
			bua_pkg::SET_DDR: begin
				set_first = bua_pkg::DDR_FIRST;
				set_last  = bua_pkg::DDR_LAST;
			end
			bua_pkg::SET_RIGHT: begin
				set_first = bua_pkg::RIGHT_FIRST;
				set_last  = bua_pkg::RIGHT_LAST;
			end
			bua_pkg::SET_CPU: begin
				set_first = bua_pkg::CPU_FIRST;
				set_last  = bua_pkg::CPU_LAST;
			end
			default: begin
				set_invalid = 1'b1;
			end
		endcase
	end

	// Any overflow mark among the set members
	logic set_ovf;
	always_comb begin
		set_ovf = 1'b0;
		for (int i = 0; i < NUM_MONITORS; i++) begin
			if (i >= int'(set_first) && i <= int'(set_last) && ovf_q[i]) begin
				set_ovf = 1'b1;
			end
		end
	end

	// Shared accumulator read port
	logic          idx_ok;
	logic [AW-1:0] rd_idx;
	logic [CW-1:0] rd_data;
	logic [CW-1:0] rd_cyc;
	assign idx_ok  = int'(item_q.monitor_index) < NUM_MONITORS;
	assign rd_idx  = cmd.add ? AW'(item_q.monitor_index) : AW'(mem_q);
	assign rd_data = data_sum_q[rd_idx];
	assign rd_cyc  = cycle_sum_q[rd_idx];

	// Snapshot add, carry out of the cycle sum or the overflow input marks overflow
	logic [CW-1:0] add_data;
	logic [CW:0]   add_cyc;
	assign add_data = rd_data + CW'(item_q.data_count);
	assign add_cyc  = {1'b0, rd_cyc} + {1'b0, CW'(item_q.cycle_count)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MONITORS; i++) begin
				data_sum_q[i]  <= '0;
				cycle_sum_q[i] <= '0;
			end
			ovf_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_MONITORS; i++) begin
				data_sum_q[i]  <= '0;
				cycle_sum_q[i] <= '0;
			end
			ovf_q <= '0;
		end else if (cmd.add && idx_ok) begin
			data_sum_q[rd_idx]  <= add_data;
			cycle_sum_q[rd_idx] <= add_cyc[CW-1:0];
			if (add_cyc[CW] || item_q.cycle_overflow_in) begin
				ovf_q[rd_idx] <= 1'b1;
			end
		end
	end

	// count*100 as shift-add
	logic [PW-1:0] prod;
	logic [PW-1:0] d_ext;
	assign d_ext = PW'(rd_data);
	assign prod  = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);

	// Restoring divider step, one quotient bit a cycle
	logic [CW:0] rem_ext;
	logic [CW:0] rem_diff;
	logic        rem_ge;
	assign rem_ext  = {rem_q, dq_q[PW-1]};
	assign rem_ge   = rem_ext >= {1'b0, div_q};
	assign rem_diff = rem_ext - {1'b0, div_q};

	logic [30:0] member_val;
	assign member_val = zero_q ? zsat_q : sat31(QW'(dq_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q  <= rd_cyc;
			rem_q  <= '0;
			dq_q   <= prod;
			cnt_q  <= CNTW'(PW - 1);
			zero_q <= (rd_cyc == '0);
			zsat_q <= sat31(QW'(prod));
		end else if (cmd.step) begin
			rem_q <= rem_ge ? rem_diff[CW-1:0] : rem_ext[CW-1:0];
			dq_q  <= {dq_q[PW-2:0], rem_ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Member walk and running maximum
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			mem_q  <= set_first;
			best_q <= '0;
		end else if (cmd.fold) begin
			mem_q <= mem_q + 1'b1;
			if (member_val > best_q) begin
				best_q <= member_val;
			end
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.status     <= cmd.emit_code;
			result_q.busy_value <= (cmd.emit_code == bua_pkg::STAT_OK) ? best_q : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	assign sts.in_query    = (item.opcode == bua_pkg::OP_QUERY);
	assign sts.set_invalid = set_invalid;
	assign sts.set_ovf     = set_ovf;
	assign sts.member_end  = (mem_q > set_last) || (int'(mem_q) >= NUM_MONITORS);
	assign sts.div_zero    = (rd_cyc == '0);
	assign sts.div_last    = (cnt_q == '0);

	`BUA_ASSERT_NEXT(a_clear_marks, clk, arst_n, cmd.clear, ovf_q == '0, "marks not cleared")
	`BUA_ASSERT_NEXT(a_fold_grows, clk, arst_n, cmd.fold, best_q >= $past(best_q), "max shrank")

endmodule

>>> hdl/bus_utilization_accumulator_core.sv
// Add beat: busy in the add state after accept, no result.
// Query beat: the set is checked, then each member is loaded, divided by the shared restoring
// divider (one quotient bit a cycle over COUNT_WIDTH+7 bits) and folded into the maximum; a
// member with zero cycles skips the divider; invalid or overflowed sets strobe after the check.
// Busy drops with the strobe: one beat at a time, result strobed for one cycle, no stall.
// arst_n clears all sums, overflow marks, the controller and the result strobe.
`include "bus_utilization_accumulator_core_macros.svh"

module bus_utilization_accumulator_core #(
	parameter int NUM_MONITORS = 5,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bua_pkg::in_item_t item,
	output logic              done,
	output bua_pkg::result_t  result
);

	bua_pkg::cmd_t cmd;
	bua_pkg::sts_t sts;

	bua_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	bua_dp #(
		.NUM_MONITORS (NUM_MONITORS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	// Add beat accepted this cycle
	logic add_accept;
	assign add_accept = start && !busy && (item.opcode == bua_pkg::OP_ADD);

	`BUA_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result while busy")
	`BUA_ASSERT(a_add_silent, clk, arst_n, add_accept |=> ##1 !done, "add gave a result")

endmodule
